// ----- rtl/ctp_pkg.sv -----
// ----------------------------------------------------------------------------
// ctp_pkg
// shared types, op codes and limits of the countdown timer pool
// ----------------------------------------------------------------------------
package ctp_pkg;

  localparam int POOL_SIZE_DEF = 32;
  localparam int MAX_RESULTS   = 32;
  localparam int COUNT_W       = 32;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_ALLOC  = 3'd1;
  localparam logic [2:0] OP_FREE   = 3'd2;
  localparam logic [2:0] OP_START  = 3'd3;
  localparam logic [2:0] OP_STOP   = 3'd4;
  localparam logic [2:0] OP_RESUME = 3'd5;
  localparam logic [2:0] OP_QUERY  = 3'd6;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  timer_id;
    logic [31:0] load_value;
    logic        with_callback;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic [4:0] slot;
    logic       ok;
    logic       is_elapsed;
    logic       last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic take;        // latch the input word
    logic idx_clr;     // restart the timer walk
    logic idx_inc;     // advance the timer walk
    logic tick_rd;     // read count at the walk index
    logic tick_step;   // write back count, handle fire
    logic alloc_take;  // claim the timer at the walk index
    logic query_rd;    // read count of the target timer
    logic reply;       // send reply word, apply command
    logic flush;       // send held fire word as last
  } ctp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_done;
    logic alloc_free;
    logic tick_blocked;
    logic pend_valid;
    logic out_free;
  } ctp_stat_t;

endpackage

// ----- rtl/ctp_ram.sv -----
// ----------------------------------------------------------------------------
// ctp_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ctp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/ctp_ctrl.sv -----
// ----------------------------------------------------------------------------
// ctp_ctrl
// sequencer of the timer pool: command decode, tick walk, allocate scan
// ----------------------------------------------------------------------------
module ctp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [2:0]         in_op,
  output logic               in_stall,
  input  ctp_pkg::ctp_stat_t stat,
  output ctp_pkg::ctp_cmd_t  cmd
);

  import ctp_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_TICK_RD  = 3'd1;
  localparam logic [2:0] S_TICK_WR  = 3'd2;
  localparam logic [2:0] S_TICK_END = 3'd3;
  localparam logic [2:0] S_ALLOC    = 3'd4;
  localparam logic [2:0] S_QRD      = 3'd5;
  localparam logic [2:0] S_REPLY    = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          case (in_op)
            OP_TICK: begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_TICK_RD;
            end
            OP_ALLOC: begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_ALLOC;
            end
            OP_QUERY: state_nxt = S_QRD;
            default:  state_nxt = S_REPLY;
          endcase
        end
      end
      S_TICK_RD: begin
        if (stat.idx_done) begin
          state_nxt = S_TICK_END;
        end else begin
          cmd.tick_rd = 1'b1;
          state_nxt   = S_TICK_WR;
        end
      end
      S_TICK_WR: begin
        if (!stat.tick_blocked) begin
          cmd.tick_step = 1'b1;
          cmd.idx_inc   = 1'b1;
          state_nxt     = S_TICK_RD;
        end
      end
      S_TICK_END: begin
        if (!stat.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ALLOC: begin
        if (stat.idx_done) begin
          state_nxt = S_REPLY;
        end else if (stat.alloc_free) begin
          cmd.alloc_take = 1'b1;
          state_nxt      = S_REPLY;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_QRD: begin
        cmd.query_rd = 1'b1;
        state_nxt    = S_REPLY;
      end
      S_REPLY: begin
        if (stat.out_free) begin
          cmd.reply = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/ctp_dp.sv -----
// ----------------------------------------------------------------------------
// ctp_dp
// datapath of the timer pool: flags, count ram, fire hold stage, output word
// ----------------------------------------------------------------------------
module ctp_dp #(
  parameter int POOL_SIZE = ctp_pkg::POOL_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctp_pkg::in_word_t  in_word,
  input  ctp_pkg::ctp_cmd_t  cmd,
  output ctp_pkg::ctp_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall,
  output ctp_pkg::out_word_t out_word
);

  import ctp_pkg::*;

  localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CW = IW + 1;
  localparam int FW = $clog2(MAX_RESULTS + 1);

  // latched command word
  logic [2:0]         op_r;
  logic [IW-1:0]      tgt_r;
  logic               tvalid_r;
  logic [COUNT_W-1:0] load_r;
  logic               item_cb_r;

  // per-timer flags; cnt_ok_r low means the count reads as zero
  logic [POOL_SIZE-1:0] alloc_r;
  logic [POOL_SIZE-1:0] active_r;
  logic [POOL_SIZE-1:0] cb_r;
  logic [POOL_SIZE-1:0] cnt_ok_r;

  logic [CW-1:0] idx_r;
  logic [IW-1:0] idx;
  logic [8:0]    idx_ext;
  logic          idx_done;

  logic [FW-1:0] fire_cnt_r;
  logic          pend_valid_r;
  logic [4:0]    pend_slot_r;
  logic          alloc_ok_r;
  logic [4:0]    alloc_slot_r;

  logic               out_valid_r;
  out_word_t          out_word_r;
  logic               out_free;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;
  logic               ram_re;
  logic [IW-1:0]      ram_raddr;
  logic [COUNT_W-1:0] ram_rdata;

  logic [COUNT_W-1:0] cur_cnt;
  logic [COUNT_W-1:0] new_cnt;
  logic [COUNT_W-1:0] q_cnt;
  logic               fire_hit;

  logic      push;
  out_word_t push_word;
  out_word_t reply_word;
  out_word_t fire_word;

  assign idx      = idx_r[IW-1:0];
  assign idx_ext  = 9'(idx);
  assign idx_done = (idx_r == CW'(POOL_SIZE));
  assign out_free = !out_valid_r || !out_stall;

  // tick step on the timer at the walk index
  assign cur_cnt  = cnt_ok_r[idx] ? ram_rdata : '0;
  assign new_cnt  = (active_r[idx] && (cur_cnt != '0)) ? cur_cnt - 1'b1 : cur_cnt;
  assign fire_hit = active_r[idx] && cb_r[idx] && (new_cnt == COUNT_W'(1))
                    && (fire_cnt_r < FW'(MAX_RESULTS));

  assign q_cnt = cnt_ok_r[tgt_r] ? ram_rdata : '0;

  assign stat.idx_done     = idx_done;
  assign stat.alloc_free   = !idx_done && !alloc_r[idx];
  assign stat.tick_blocked = fire_hit && pend_valid_r && !out_free;
  assign stat.pend_valid   = pend_valid_r;
  assign stat.out_free     = out_free;

  assign ram_we    = cmd.tick_step || (cmd.reply && tvalid_r && (op_r == OP_START));
  assign ram_waddr = cmd.tick_step ? idx : tgt_r;
  assign ram_wdata = cmd.tick_step ? new_cnt : load_r;
  assign ram_re    = cmd.tick_rd || cmd.query_rd;
  assign ram_raddr = cmd.tick_rd ? idx : tgt_r;

  ctp_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(POOL_SIZE)
  ) u_cnt_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  always_comb begin
    reply_word            = '0;
    reply_word.last       = 1'b1;
    reply_word.slot       = ((op_r == OP_ALLOC) && alloc_ok_r) ? alloc_slot_r : 5'd0;
    reply_word.is_elapsed = (op_r == OP_QUERY) && tvalid_r && (q_cnt == '0);
    case (op_r)
      OP_ALLOC:  reply_word.ok = alloc_ok_r;
      OP_FREE,
      OP_START,
      OP_STOP,
      OP_RESUME,
      OP_QUERY:  reply_word.ok = tvalid_r;
      default:   reply_word.ok = 1'b0;
    endcase
  end

  always_comb begin
    fire_word            = '0;
    fire_word.kind       = 1'b1;
    fire_word.slot       = pend_slot_r;
    fire_word.ok         = 1'b1;
    fire_word.last       = cmd.flush;
  end

  assign push      = cmd.reply || cmd.flush || (cmd.tick_step && fire_hit && pend_valid_r);
  assign push_word = cmd.reply ? reply_word : fire_word;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r      <= in_word.op;
      tvalid_r  <= (int'(in_word.timer_id) < POOL_SIZE);
      tgt_r     <= (int'(in_word.timer_id) < POOL_SIZE) ? IW'(in_word.timer_id) : '0;
      load_r    <= in_word.load_value;
      item_cb_r <= in_word.with_callback;
    end
    if (cmd.alloc_take) begin
      alloc_slot_r <= idx_ext[4:0];
    end
    if (cmd.tick_step && fire_hit) begin
      pend_slot_r <= idx_ext[4:0];
    end
    if (push) begin
      out_word_r <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r      <= '0;
      active_r     <= '0;
      cb_r         <= '0;
      cnt_ok_r     <= '0;
      idx_r        <= '0;
      fire_cnt_r   <= '0;
      pend_valid_r <= 1'b0;
      alloc_ok_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.take) begin
        alloc_ok_r <= 1'b0;
      end
      if (cmd.idx_clr) begin
        idx_r      <= '0;
        fire_cnt_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.alloc_take) begin
        alloc_r[idx]  <= 1'b1;
        cb_r[idx]     <= 1'b0;
        cnt_ok_r[idx] <= 1'b0;
        alloc_ok_r    <= 1'b1;
      end
      if (cmd.tick_step) begin
        cnt_ok_r[idx] <= 1'b1;
        if (fire_hit) begin
          pend_valid_r <= 1'b1;
          fire_cnt_r   <= fire_cnt_r + 1'b1;
        end
      end
      if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
      if (cmd.reply && tvalid_r) begin
        case (op_r)
          OP_FREE: begin
            active_r[tgt_r] <= 1'b0;
            alloc_r[tgt_r]  <= 1'b0;
            cb_r[tgt_r]     <= 1'b0;
            cnt_ok_r[tgt_r] <= 1'b0;
          end
          OP_START: begin
            cnt_ok_r[tgt_r] <= 1'b1;
            cb_r[tgt_r]     <= item_cb_r;
            active_r[tgt_r] <= 1'b1;
          end
          OP_STOP:   active_r[tgt_r] <= 1'b0;
          OP_RESUME: active_r[tgt_r] <= 1'b1;
          default: ;
        endcase
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- rtl/countdown_timer_pool.sv -----
// ----------------------------------------------------------------------------
// countdown_timer_pool
// pool of 32-bit countdown timers with allocate, free, start, stop, resume,
// query and tick commands; ticks report fire words in ascending id order
// ----------------------------------------------------------------------------
//
//   channel  direction  word         handshake
//   in_      input      in_word_t    in_valid / in_stall
//   out_     output     out_word_t   out_valid / out_stall
//
// one word is taken at a time; in_stall is high until its work is done
// tick: a read-modify-write walk through the single count ram, timer by
//   timer, then the end-of-walk check and the closing step that sends the
//   held fire word
// allocate: scans the timers in id order for the free flag, up to the first
//   free one; free, start, stop, resume: reply only; query: count ram read
// synchronous active-low reset clears all flags at once; a cleared count
//   flag makes its ram entry read as zero, so no clearing pass is needed
// out_stall holds the output register; the walk waits in place while a
//   fire word cannot move on
//
module countdown_timer_pool #(
  parameter int POOL_SIZE = ctp_pkg::POOL_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // command words
  input  logic               in_valid,
  output logic               in_stall,
  input  ctp_pkg::in_word_t  in_word,
  // reply and fire words
  output logic               out_valid,
  input  logic               out_stall,
  output ctp_pkg::out_word_t out_word
);

  import ctp_pkg::*;

  // command and status between sequencer and datapath
  ctp_cmd_t  cmd;
  ctp_stat_t stat;

  // sequencer: decode, tick walk, allocate scan, reply timing
  ctp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_op   (in_word.op),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  // datapath: timer flags, count ram, fire hold stage, output register
  ctp_dp #(
    .POOL_SIZE(POOL_SIZE)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

endmodule

// ----- tb/countdown_timer_pool_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// countdown_timer_pool_checker
// watches the command and result channels, keeps its own copy of the timer
// pool, predicts every reply and fire word and compares them in order
// ----------------------------------------------------------------------------
module countdown_timer_pool_checker #(
  parameter int POOL_SIZE = ctp_pkg::POOL_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  ctp_pkg::in_word_t  in_word,
  input  logic               out_valid,
  input  logic               out_stall,
  input  ctp_pkg::out_word_t out_word,
  output int                 fail_count,
  output int                 words_due,
  output int                 fires_seen,
  output int                 replies_seen
);

  // shadow pool
  logic [ctp_pkg::COUNT_W-1:0] timer_count [POOL_SIZE];
  logic [POOL_SIZE-1:0]        taken;
  logic [POOL_SIZE-1:0]        running;
  logic [POOL_SIZE-1:0]        notify;

  ctp_pkg::out_word_t due_words[$];
  int errors;
  int fires;
  int replies;

  task automatic apply_command(input ctp_pkg::in_word_t w);
    ctp_pkg::out_word_t rsp;
    ctp_pkg::out_word_t fire;
    ctp_pkg::out_word_t fire_list[$];
    logic hit;
    int t;
    rsp = '0;
    rsp.last = 1'b1;
    hit = int'(w.timer_id) < POOL_SIZE;
    t = hit ? int'(w.timer_id) : 0;
    case (w.op)
      ctp_pkg::OP_TICK: begin
        for (int i = 0; i < POOL_SIZE; i++) begin
          if (running[i]) begin
            if (timer_count[i] != '0) timer_count[i] = timer_count[i] - 1'b1;
            if (timer_count[i] == 1 && notify[i] &&
                fire_list.size() < ctp_pkg::MAX_RESULTS) begin
              fire = '0;
              fire.kind = 1'b1;
              fire.slot = 5'(i);
              fire.ok = 1'b1;
              fire_list.push_back(fire);
            end
          end
        end
        // only the final fire word of a tick carries last
        if (fire_list.size() > 0) begin
          fire = fire_list.pop_back();
          fire.last = 1'b1;
          fire_list.push_back(fire);
        end
        foreach (fire_list[k]) due_words.push_back(fire_list[k]);
      end
      ctp_pkg::OP_ALLOC: begin
        for (int i = 0; i < POOL_SIZE; i++) begin
          if (!taken[i] && !rsp.ok) begin
            timer_count[i] = '0;
            notify[i] = 1'b0;
            taken[i] = 1'b1;
            rsp.slot = 5'(i);
            rsp.ok = 1'b1;
          end
        end
      end
      ctp_pkg::OP_FREE: begin
        if (hit) begin
          running[t] = 1'b0;
          taken[t] = 1'b0;
          timer_count[t] = '0;
          notify[t] = 1'b0;
          rsp.ok = 1'b1;
        end
      end
      ctp_pkg::OP_START: begin
        if (hit) begin
          timer_count[t] = w.load_value;
          notify[t] = w.with_callback;
          running[t] = 1'b1;
          rsp.ok = 1'b1;
        end
      end
      ctp_pkg::OP_STOP: begin
        if (hit) begin
          running[t] = 1'b0;
          rsp.ok = 1'b1;
        end
      end
      ctp_pkg::OP_RESUME: begin
        if (hit) begin
          running[t] = 1'b1;
          rsp.ok = 1'b1;
        end
      end
      ctp_pkg::OP_QUERY: begin
        if (hit) begin
          rsp.ok = 1'b1;
          rsp.is_elapsed = timer_count[t] == '0;
        end
      end
      default: begin
        // spare op code: plain failed reply
      end
    endcase
    if (w.op != ctp_pkg::OP_TICK) due_words.push_back(rsp);
  endtask

  task automatic note_failure(input string what, input ctp_pkg::out_word_t want,
                              input ctp_pkg::out_word_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s: expected kind=%0d slot=%0d ok=%0d elapsed=%0d last=%0d,",
               $realtime, what, want.kind, want.slot, want.ok, want.is_elapsed,
               want.last);
      $display("    got kind=%0d slot=%0d ok=%0d elapsed=%0d last=%0d",
               got.kind, got.slot, got.ok, got.is_elapsed, got.last);
    end
  endtask

  always @(posedge clk) begin
    ctp_pkg::out_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < POOL_SIZE; i++) timer_count[i] = '0;
      taken = '0;
      running = '0;
      notify = '0;
      due_words.delete();
      errors = 0;
      fires = 0;
      replies = 0;
    end else begin
      if (in_valid && !in_stall) apply_command(in_word);
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          note_failure("unexpected word", '0, out_word);
        end else begin
          want = due_words.pop_front();
          if (out_word !== want) note_failure("mismatch", want, out_word);
        end
        if (out_word.kind) fires++;
        else replies++;
      end
    end
    fail_count <= errors;
    words_due <= due_words.size();
    fires_seen <= fires;
    replies_seen <= replies;
  end

endmodule

// ----- tb/countdown_timer_pool_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// countdown_timer_pool_tb
// drives command words into the timer pool under changing idle and stall
// patterns; a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module countdown_timer_pool_tb;

  import ctp_pkg::*;

  // the one op code the package leaves unnamed
  localparam logic [2:0] OP_SPARE = 3'd7;
  localparam int         HOLD_CYCLES = 400;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  int fail_count;
  int words_due;
  int fires_seen;
  int replies_seen;

  // idle knobs, changed per phase
  int send_idle_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;

  // long receiver hold, requested by stimulus, timed by the receiver
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  always #5 clk = ~clk;

  countdown_timer_pool u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  countdown_timer_pool_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .fail_count   (fail_count),
    .words_due    (words_due),
    .fires_seen   (fires_seen),
    .replies_seen (replies_seen)
  );

  // receiver: random stall, or one long hold so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) < stall_pct;
    end
  end

  function automatic in_word_t cmd(input logic [2:0] op, input logic [7:0] id,
                                   input logic [31:0] load, input logic cb);
    in_word_t w;
    w.op = op;
    w.timer_id = id;
    w.load_value = load;
    w.with_callback = cb;
    return w;
  endfunction

  // mostly in-range ids and short loads so timers actually fire,
  // with out-of-range ids, full-width loads and the spare op as noise
  function automatic in_word_t random_word();
    in_word_t w;
    int pick;
    pick = $urandom_range(99);
    if (pick < 30)      w.op = OP_TICK;
    else if (pick < 45) w.op = OP_ALLOC;
    else if (pick < 53) w.op = OP_FREE;
    else if (pick < 73) w.op = OP_START;
    else if (pick < 79) w.op = OP_STOP;
    else if (pick < 85) w.op = OP_RESUME;
    else if (pick < 97) w.op = OP_QUERY;
    else                w.op = OP_SPARE;
    if ($urandom_range(9) == 0) w.timer_id = 8'($urandom_range(255, 32));
    else                        w.timer_id = 8'($urandom_range(31));
    case ($urandom_range(6))
      0:       w.load_value = $urandom;
      1:       w.load_value = 32'($urandom_range(40, 7));
      default: w.load_value = 32'($urandom_range(6));
    endcase
    w.with_callback = $urandom_range(9) < 7;
    return w;
  endfunction

  // offer one word, with random idle cycles ahead of it; returns on the
  // edge where it is taken
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  initial begin
    in_valid = 1'b0;
    in_word = '0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty tick, first allocations, fire on the way down to one,
    // zero and full-scale loads, unallocated and out-of-range ids, spare op
    send_word(cmd(OP_TICK, 8'd0, 32'd0, 1'b0));
    send_word(cmd(OP_ALLOC, 8'd0, 32'd0, 1'b0));
    send_word(cmd(OP_ALLOC, 8'd0, 32'd0, 1'b0));
    send_word(cmd(OP_START, 8'd0, 32'd2, 1'b1));
    send_word(cmd(OP_START, 8'd1, 32'hFFFF_FFFF, 1'b0));
    send_word(cmd(OP_QUERY, 8'd0, 32'd0, 1'b0));
    send_word(cmd(OP_TICK, 8'd0, 32'd0, 1'b0));
    send_word(cmd(OP_TICK, 8'd0, 32'd0, 1'b0));
    send_word(cmd(OP_QUERY, 8'd0, 32'd0, 1'b0));
    send_word(cmd(OP_TICK, 8'd0, 32'd0, 1'b0));
    send_word(cmd(OP_START, 8'd31, 32'd0, 1'b1));
    send_word(cmd(OP_START, 8'd2, 32'd1, 1'b1));
    send_word(cmd(OP_TICK, 8'd0, 32'd0, 1'b0));
    send_word(cmd(OP_STOP, 8'd1, 32'd0, 1'b0));
    send_word(cmd(OP_RESUME, 8'd1, 32'd0, 1'b0));
    send_word(cmd(OP_FREE, 8'd1, 32'd0, 1'b0));
    send_word(cmd(OP_QUERY, 8'd255, 32'd0, 1'b0));
    send_word(cmd(OP_START, 8'd32, 32'hFFFF_FFFF, 1'b1));
    send_word(cmd(OP_FREE, 8'd200, 32'd0, 1'b0));
    send_word(cmd(OP_STOP, 8'd255, 32'd0, 1'b0));
    send_word(cmd(OP_RESUME, 8'd32, 32'd0, 1'b0));
    send_word(cmd(OP_SPARE, 8'hFF, 32'hFFFF_FFFF, 1'b1));
    send_word(cmd(OP_ALLOC, 8'd0, 32'd0, 1'b0));
    send_word(cmd(OP_TICK, 8'd0, 32'd0, 1'b0));

    // random phases; all but the first open with a burst of well-formed commands
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          // no idling; receiver freezes for a while so the block backs up
          send_idle_pct = 0;
          stall_pct <= 0;
          hold_req <= 1'b1;
        end
        1: begin
          // sender mostly idle; fill the pool and overflow it
          send_idle_pct = 84;
          stall_pct <= 0;
          for (int i = 0; i < 34; i++) send_word(cmd(OP_ALLOC, 8'd0, $urandom, 1'b0));
        end
        2: begin
          // receiver mostly stalled; every timer fires on the same tick
          send_idle_pct = 0;
          stall_pct <= 84;
          for (int i = 0; i < 32; i++) send_word(cmd(OP_START, 8'(i), 32'd2, 1'b1));
          send_word(cmd(OP_TICK, 8'd0, 32'd0, 1'b0));
          send_word(cmd(OP_TICK, 8'd0, 32'd0, 1'b0));
        end
        default: begin
          // both sides idle now and then; release the whole pool
          send_idle_pct = 26;
          stall_pct <= 26;
          for (int i = 0; i < 32; i++) send_word(cmd(OP_FREE, 8'(i), $urandom, 1'b1));
        end
      endcase
      for (int n = 0; n < 60; n++) send_word(random_word());
    end
    in_valid <= 1'b0;

    // let the checker count the last word, drain, then give a late extra
    // word time to show up
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("ran %0d command words through four idle and stall patterns",
             words_sent);
    $display("checked %0d replies and %0d fire words, including a full pool and a 32-fire tick",
             replies_seen, fires_seen);
    if (fail_count == 0 && words_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #(20_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule
